// ===== rtl/sulet_pkg.sv =====
// Shared types, constants and frame table of the SET/UA link establishment transmitter.
package sulet_pkg;

    // Frame bytes
    localparam logic [7:0] FLAG_BYTE = 8'h5C;
    localparam logic [7:0] ADDR_TX   = 8'h01;
    localparam logic [7:0] CTRL_SET  = 8'h03;
    localparam logic [7:0] ADDR_RX   = 8'h03;
    localparam logic [7:0] CTRL_UA   = 8'h07;
    localparam logic [7:0] BCC_SET   = ADDR_TX ^ CTRL_SET;
    localparam logic [7:0] BCC_UA    = ADDR_RX ^ CTRL_UA;

    // SET frame length and index width
    localparam int unsigned FRAME_LEN = 5;
    localparam int unsigned FIDX_W    = $clog2(FRAME_LEN);
    localparam logic [FIDX_W-1:0] FIDX_LAST = FIDX_W'(FRAME_LEN - 1);

    // Field widths
    localparam int unsigned TICK_W = 16;
    localparam int unsigned TOUT_W = 4;
    localparam int unsigned CFG_W  = 16;
    localparam logic [TOUT_W-1:0] TOUT_SAT = '1;

    // Function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_RXB   = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT_TICKS = 1'b0;
    localparam logic CFG_MAX_TIMEOUTS  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_OK   = 2'd2,
        PH_FAIL = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        RX_HUNT = 3'd0,
        RX_ADDR = 3'd1,
        RX_CTRL = 3'd2,
        RX_BCC  = 3'd3,
        RX_END  = 3'd4
    } t_rx_stage;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic [1:0] link_status;
    } t_out_item;

    // Work handed from front to back: a SET frame or a single status item
    typedef struct packed {
        logic       send_frame;
        logic [1:0] status;
    } t_job;

    function automatic logic [7:0] frame_byte(input logic [FIDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = FLAG_BYTE;
            3'd1:    b = ADDR_TX;
            3'd2:    b = CTRL_SET;
            3'd3:    b = BCC_SET;
            default: b = FLAG_BYTE;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/sulet_front.sv =====
// Front end: takes items, runs the UA recogniser, timers and link phase, issues jobs.
module sulet_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  sulet_pkg::t_in_item  i_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    output sulet_pkg::t_job      o_job
);
    import sulet_pkg::*;

    t_phase              r_phase,         n_phase;
    t_rx_stage           r_rx_stage,      n_rx_stage;
    logic [TICK_W-1:0]   r_tick_count,    n_tick_count;
    logic [TOUT_W-1:0]   r_timeout_count, n_timeout_count;
    logic [TICK_W-1:0]   r_timeout_ticks;
    logic [TOUT_W-1:0]   r_max_timeouts;
    logic [TICK_W-1:0]   tick_inc;
    logic [TOUT_W-1:0]   tout_inc;
    logic                send_frame;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TICK_W'(3);
            r_max_timeouts  <= TOUT_W'(3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_MAX_TIMEOUTS:  r_max_timeouts  <= i_cfg_data[TOUT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Link state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_rx_stage      <= RX_HUNT;
            r_tick_count    <= '0;
            r_timeout_count <= '0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_rx_stage      <= n_rx_stage;
            r_tick_count    <= n_tick_count;
            r_timeout_count <= n_timeout_count;
        end
    end

    assign tick_inc = r_tick_count + TICK_W'(1);
    assign tout_inc = (r_timeout_count == TOUT_SAT) ? TOUT_SAT
                                                    : r_timeout_count + TOUT_W'(1);

    // Next state and job for the item on the input
    always_comb begin
        n_phase         = r_phase;
        n_rx_stage      = r_rx_stage;
        n_tick_count    = r_tick_count;
        n_timeout_count = r_timeout_count;
        send_frame      = 1'b0;
        unique case (i_item.func)
            FUNC_START: begin
                n_phase         = PH_WAIT;
                n_rx_stage      = RX_HUNT;
                n_tick_count    = '0;
                n_timeout_count = '0;
                send_frame      = 1'b1;
            end
            FUNC_RXB: begin
                if (r_phase == PH_WAIT) begin
                    unique case (r_rx_stage)
                        RX_HUNT: begin
                            if (i_item.rx_byte == FLAG_BYTE) n_rx_stage = RX_ADDR;
                        end
                        RX_ADDR: begin
                            if (i_item.rx_byte == ADDR_RX)        n_rx_stage = RX_CTRL;
                            else if (i_item.rx_byte != FLAG_BYTE) n_rx_stage = RX_HUNT;
                        end
                        RX_CTRL: begin
                            if (i_item.rx_byte == CTRL_UA)        n_rx_stage = RX_BCC;
                            else if (i_item.rx_byte == FLAG_BYTE) n_rx_stage = RX_ADDR;
                            else                                  n_rx_stage = RX_HUNT;
                        end
                        RX_BCC: begin
                            if (i_item.rx_byte == BCC_UA)         n_rx_stage = RX_END;
                            else if (i_item.rx_byte == FLAG_BYTE) n_rx_stage = RX_ADDR;
                            else                                  n_rx_stage = RX_HUNT;
                        end
                        RX_END: begin
                            // closing flag completes the UA
                            if (i_item.rx_byte == FLAG_BYTE) begin
                                n_phase         = PH_OK;
                                n_tick_count    = '0;
                                n_timeout_count = '0;
                            end
                            n_rx_stage = RX_HUNT;
                        end
                        default: n_rx_stage = RX_HUNT;
                    endcase
                end
            end
            FUNC_TICK: begin
                if (r_phase == PH_WAIT) begin
                    if (tick_inc >= r_timeout_ticks) begin
                        n_tick_count    = '0;
                        n_timeout_count = tout_inc;
                        if (tout_inc >= r_max_timeouts) begin
                            n_phase = PH_FAIL;
                        end else begin
                            n_rx_stage = RX_HUNT;
                            send_frame = 1'b1;
                        end
                    end else begin
                        n_tick_count = tick_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_job.send_frame = send_frame;
    assign o_job.status     = n_phase;

endmodule

// ===== rtl/sulet_jobq.sv =====
// Job queue between front and back ends.
module sulet_jobq #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  sulet_pkg::t_job  i_job,
    output logic             o_full,
    input  logic             i_rd,
    output sulet_pkg::t_job  o_job,
    output logic             o_empty
);
    import sulet_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic            wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_job   = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wptr] <= i_job;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            if (rd_en) r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            if (wr_en && !rd_en)      r_count <= r_count + CW'(1);
            else if (rd_en && !wr_en) r_count <= r_count - CW'(1);
        end
    end

endmodule

// ===== rtl/sulet_back.sv =====
// Back end: expands jobs into result items and holds the output register.
module sulet_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sulet_pkg::t_job      i_job,
    input  logic                 i_job_valid,
    output logic                 o_job_done,
    output sulet_pkg::t_out_item o_item,
    output logic                 o_empty,
    input  logic                 i_pop
);
    import sulet_pkg::*;

    logic              r_out_valid;
    t_out_item         r_out;
    logic [FIDX_W-1:0] r_idx;
    logic              load, step;
    t_out_item         n_out;

    assign load       = !r_out_valid || i_pop;
    assign step       = load && i_job_valid;
    assign o_job_done = step && n_out.last;

    // Build the next result item from the head job
    always_comb begin
        n_out.link_status = i_job.status;
        if (i_job.send_frame) begin
            n_out.tx_valid = 1'b1;
            n_out.tx_byte  = frame_byte(r_idx);
            n_out.last     = (r_idx == FIDX_LAST);
        end else begin
            n_out.tx_valid = 1'b0;
            n_out.tx_byte  = '0;
            n_out.last     = 1'b1;
        end
    end

    // Frame byte counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) r_out_valid <= i_job_valid;
            if (o_job_done) r_idx <= '0;
            else if (step)  r_idx <= r_idx + FIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) r_out <= n_out;
    end

    assign o_item  = r_out;
    assign o_empty = !r_out_valid;

endmodule

// ===== rtl/set_ua_link_establish_tx_unit.sv =====
// Top level of the SET/UA link establishment transmitter.
//
// Items enter through a queue-style port (push/full) and results leave through
// another (empty/pop). The front end takes one item per cycle while full is low:
// it updates the UA recogniser, tick and timeout counters and link phase at once
// and queues a job in a JOB_DEPTH-entry queue. The back end turns each job into
// results from its output register: a start or resend yields the five SET frame
// bytes, one per cycle while popped, any other item one status result. It thus
// sustains one status-only item per cycle, set by its single output register,
// while a frame send holds it for all five bytes. Full rises only when JOB_DEPTH
// jobs are waiting. Configuration: i_cfg_idx 0 is timeout_ticks, 1 is
// max_timeouts; the user writes them only while the block is idle (unenforced).
module set_ua_link_establish_tx_unit #(
    parameter int unsigned JOB_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  sulet_pkg::t_in_item  i_item,
    output logic                 empty,
    input  logic                 pop,
    output sulet_pkg::t_out_item o_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);
    import sulet_pkg::*;

    logic accept;
    t_job front_job, head_job;
    logic q_empty, job_done;

    assign accept = push && !full;

    sulet_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_job      (front_job)
    );

    sulet_jobq #(.DEPTH(JOB_DEPTH)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_job   (front_job),
        .o_full  (full),
        .i_rd    (job_done),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    sulet_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (!q_empty),
        .o_job_done  (job_done),
        .o_item      (o_item),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

// ===== rtl/sulet_checker.sv =====
// Port-level checks for the link establishment transmitter, bound to the top level.
module sulet_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 empty,
    input logic                 pop,
    input sulet_pkg::t_out_item o_item
);
    import sulet_pkg::*;

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("stalled result changed");

    // Status-only results are single and carry no byte
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_item.tx_valid) |-> (o_item.last && o_item.tx_byte == 8'h00))
        else $error("malformed status result");

    // A frame continues without a gap once started
    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_item.tx_valid && !o_item.last) |=> (!empty && o_item.tx_valid))
        else $error("SET frame broken");

    // Frame bytes are only sent while waiting for UA
    a_frame_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.tx_valid) |-> (o_item.link_status == PH_WAIT))
        else $error("frame byte outside waiting phase");

endmodule

bind set_ua_link_establish_tx_unit sulet_checker u_sulet_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);
